>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/ubfb_pkg.sv
// Package: types and constants of the UART ring FIFO bridge.
package ubfb_pkg;

  // Default ring depth in bytes
  localparam int unsigned RING_DEPTH_DEF = 512;

  // Item kinds
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_EVENT = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

endpackage

>>> rtl/uart_buffered_fifo_bridge_unit.sv
// Top level: transmit and receive byte rings between a host and a UART.
//
//  channel | ports               | transfer when
//  --------+---------------------+-----------------------------
//  input   | start, busy, in_*   | start high and busy low
//  result  | out_valid, out_*    | out_valid high (one cycle)
//
// Each item is handled by an accept edge, which reads both ring RAMs at
// their tail entries, and an execute edge, which writes back, moves
// pointers and registers the result. busy is high during the execute
// cycle only, so a new item may be accepted while the previous result is
// shown. Reset is synchronous and clears pointers, levels and flags; ring
// contents are not cleared. The receiver cannot stall.
module uart_buffered_fifo_bridge_unit #(
  parameter int unsigned RING_DEPTH = ubfb_pkg::RING_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_func,
  input  logic [7:0]                         in_host_byte,
  input  logic                               in_tx_empty,
  input  logic                               in_rx_full,
  input  logic                               in_noise_error,
  input  logic                               in_framing_error,
  input  logic [7:0]                         in_rx_byte,
  output logic                               out_valid,
  output logic                               out_accepted,
  output logic [7:0]                         out_read_byte,
  output logic                               out_send_valid,
  output logic [7:0]                         out_send_byte,
  output logic [$clog2(RING_DEPTH+1)-1:0]    out_free_space,
  output logic                               out_tx_irq_on,
  output logic                               out_rx_dropped
);
  import ubfb_pkg::*;

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned LVL_W = $clog2(RING_DEPTH + 1);
  localparam logic [LVL_W-1:0] DEPTH_L = LVL_W'(RING_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(RING_DEPTH - 1);

  // Ring storage
  logic [7:0] tx_mem [RING_DEPTH];
  logic [7:0] rx_mem [RING_DEPTH];

  // Control state
  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [PTR_W-1:0]   rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [LVL_W-1:0]   tx_level_r, tx_level_nxt, rx_level_r, rx_level_nxt;
  logic               tx_running_r, tx_running_nxt;
  logic               tx_irq_r, tx_irq_nxt;
  logic               out_valid_r;

  // Latched item and RAM read data
  func_t              func_r;
  logic [7:0]         host_byte_r, rx_byte_r;
  logic               tx_empty_r, rx_full_r, rx_err_r;
  logic [7:0]         tx_rd_r, rx_rd_r;

  // Result registers
  logic               accepted_r, send_valid_r, rx_dropped_r;
  logic [7:0]         read_byte_r, send_byte_r;
  logic [LVL_W-1:0]   free_space_r;

  logic accept;
  logic tx_push, tx_pop, rx_push, rx_pop, rx_drop;
  logic [LVL_W-1:0] tx_lvl_pushed;
  logic [7:0] send_byte_c;

  assign accept = start && (state_r == ST_IDLE);

  // Next state
  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    unique case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_EXEC: busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  // Latch the item and read both tails on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r      <= func_t'(in_func);
      host_byte_r <= in_host_byte;
      rx_byte_r   <= in_rx_byte;
      tx_empty_r  <= in_tx_empty;
      rx_full_r   <= in_rx_full;
      rx_err_r    <= in_noise_error | in_framing_error;
      tx_rd_r     <= tx_mem[tx_tail_r];
      rx_rd_r     <= rx_mem[rx_tail_r];
    end
  end

  // Push/pop decisions for the execute cycle
  always_comb begin
    tx_push       = (func_r == FUNC_WRITE) && (tx_level_r != DEPTH_L);
    tx_lvl_pushed = tx_level_r + LVL_W'(tx_push);
    tx_pop        = ((func_r == FUNC_WRITE) && !tx_running_r && (tx_lvl_pushed != '0)) ||
                    ((func_r == FUNC_EVENT) && (tx_level_r != '0) && tx_empty_r);
    rx_pop        = (func_r == FUNC_READ) && (rx_level_r != '0);
    rx_push       = (func_r == FUNC_EVENT) && rx_full_r && !rx_err_r &&
                    (rx_level_r != DEPTH_L);
    rx_drop       = (func_r == FUNC_EVENT) && rx_full_r && !rx_push;
    // Empty ring: the popped byte is the one written this cycle
    send_byte_c   = (tx_level_r == '0) ? host_byte_r : tx_rd_r;
  end

  // Next pointers, levels and flags
  always_comb begin
    tx_head_nxt    = tx_head_r;
    tx_tail_nxt    = tx_tail_r;
    rx_head_nxt    = rx_head_r;
    rx_tail_nxt    = rx_tail_r;
    tx_level_nxt   = tx_level_r;
    rx_level_nxt   = rx_level_r;
    tx_running_nxt = tx_running_r;
    tx_irq_nxt     = tx_irq_r;
    unique case (func_r)
      FUNC_WRITE: begin
        if (tx_push) begin
          tx_head_nxt = (tx_head_r == LAST_P) ? '0 : tx_head_r + PTR_W'(1);
        end
        tx_level_nxt = tx_lvl_pushed - LVL_W'(tx_pop);
        if (tx_pop) begin
          tx_tail_nxt    = (tx_tail_r == LAST_P) ? '0 : tx_tail_r + PTR_W'(1);
          tx_running_nxt = 1'b1;
          tx_irq_nxt     = 1'b1;
        end
      end
      FUNC_READ: begin
        if (rx_pop) begin
          rx_tail_nxt  = (rx_tail_r == LAST_P) ? '0 : rx_tail_r + PTR_W'(1);
          rx_level_nxt = rx_level_r - LVL_W'(1);
        end
      end
      FUNC_EVENT: begin
        if (tx_level_r == '0) begin
          tx_running_nxt = 1'b0;
          tx_irq_nxt     = 1'b0;
        end else if (tx_pop) begin
          tx_tail_nxt    = (tx_tail_r == LAST_P) ? '0 : tx_tail_r + PTR_W'(1);
          tx_level_nxt   = tx_level_r - LVL_W'(1);
          tx_running_nxt = 1'b1;
        end
        if (rx_push) begin
          rx_head_nxt  = (rx_head_r == LAST_P) ? '0 : rx_head_r + PTR_W'(1);
          rx_level_nxt = rx_level_r + LVL_W'(1);
        end
      end
      FUNC_CLEAR: begin
        tx_head_nxt    = '0;
        tx_tail_nxt    = '0;
        rx_head_nxt    = '0;
        rx_tail_nxt    = '0;
        tx_level_nxt   = '0;
        rx_level_nxt   = '0;
        tx_running_nxt = 1'b0;
        tx_irq_nxt     = 1'b0;
      end
      default: begin
        tx_level_nxt = tx_level_r;
      end
    endcase
  end

  // Ring writes in the execute cycle
  always_ff @(posedge clk) begin
    if ((state_r == ST_EXEC) && tx_push) begin
      tx_mem[tx_head_r] <= host_byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_EXEC) && rx_push) begin
      rx_mem[rx_head_r] <= rx_byte_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tx_head_r    <= '0;
      tx_tail_r    <= '0;
      rx_head_r    <= '0;
      rx_tail_r    <= '0;
      tx_level_r   <= '0;
      rx_level_r   <= '0;
      tx_running_r <= 1'b0;
      tx_irq_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_EXEC);
      if (state_r == ST_EXEC) begin
        tx_head_r    <= tx_head_nxt;
        tx_tail_r    <= tx_tail_nxt;
        rx_head_r    <= rx_head_nxt;
        rx_tail_r    <= rx_tail_nxt;
        tx_level_r   <= tx_level_nxt;
        rx_level_r   <= rx_level_nxt;
        tx_running_r <= tx_running_nxt;
        tx_irq_r     <= tx_irq_nxt;
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      accepted_r   <= tx_push | rx_pop;
      read_byte_r  <= rx_pop ? rx_rd_r : 8'd0;
      send_valid_r <= tx_pop;
      send_byte_r  <= tx_pop ? send_byte_c : 8'd0;
      free_space_r <= DEPTH_L - tx_level_nxt;
      rx_dropped_r <= rx_drop;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = accepted_r;
  assign out_read_byte  = read_byte_r;
  assign out_send_valid = send_valid_r;
  assign out_send_byte  = send_byte_r;
  assign out_free_space = free_space_r;
  assign out_tx_irq_on  = tx_irq_r;
  assign out_rx_dropped = rx_dropped_r;

endmodule

>>> rtl/ubfb_checker.sv
// Port-level checker for the UART ring FIFO bridge, bound to the top level.
`include "assert_macros.svh"

module ubfb_checker #(
  parameter int unsigned RING_DEPTH = ubfb_pkg::RING_DEPTH_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic                            out_accepted,
  input logic [7:0]                      out_read_byte,
  input logic                            out_send_valid,
  input logic [7:0]                      out_send_byte,
  input logic [$clog2(RING_DEPTH+1)-1:0] out_free_space
);
  localparam int unsigned LVL_W = $clog2(RING_DEPTH + 1);

  // An accepted item executes in the next cycle
  `ASSERT_NEXT(a_accept_exec, clk, rst_n, start && !busy, busy)
  // Execution yields exactly one result, shown in the next cycle with busy low
  `ASSERT_NEXT(a_exec_result, clk, rst_n, busy, out_valid && !busy)
  // No idle send byte
  `ASSERT_SAME(a_send_zero, clk, rst_n, out_valid && !out_send_valid, out_send_byte == 8'd0)
  // Rejected read returns zero
  `ASSERT_SAME(a_read_zero, clk, rst_n, out_valid && !out_accepted, out_read_byte == 8'd0)
  // Free space never exceeds the ring depth
  `ASSERT_SAME(a_free_range, clk, rst_n, out_valid, out_free_space <= LVL_W'(RING_DEPTH))

endmodule

bind uart_buffered_fifo_bridge_unit ubfb_checker #(.RING_DEPTH(RING_DEPTH)) u_ubfb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_accepted   (out_accepted),
  .out_read_byte  (out_read_byte),
  .out_send_valid (out_send_valid),
  .out_send_byte  (out_send_byte),
  .out_free_space (out_free_space)
);
